@@ design/b32se_pkg.sv @@
// Shared types, constants and the base32 alphabet for the base32 stream encoder.
`timescale 1ns / 1ps

package b32se_pkg;

    // Default depth of the queue between the byte front end and the character back end.
    localparam int B32SE_QUEUE_DEPTH = 4;

    localparam int SYM_W   = 7;   // ASCII character width
    localparam int GROUP_W = 5;   // one base32 digit
    localparam int MAX_CHARS = 3; // characters one byte can cause

    localparam logic [GROUP_W-1:0] LETTER_COUNT = 5'd26;
    localparam logic [SYM_W-1:0]   CHAR_A       = 7'h41; // 'A'
    localparam logic [SYM_W-1:0]   CHAR_2       = 7'h32; // '2'
    localparam logic [SYM_W-1:0]   CHAR_Z       = 7'h5A; // 'Z'
    localparam logic [SYM_W-1:0]   CHAR_7       = 7'h37; // '7'

    // One classified byte: its characters' 5-bit groups, how many of them are
    // real (1..3) and whether the byte closed the message.
    typedef struct packed {
        logic [MAX_CHARS-1:0][GROUP_W-1:0] groups;
        logic [1:0]                        n_chars;
        logic                              last;
    } b32se_entry_t;

    // Alphabet A-Z then 2-7.
    function automatic logic [SYM_W-1:0] b32_char(input logic [GROUP_W-1:0] group);
        logic [SYM_W-1:0] ch;
        if (group < LETTER_COUNT)
        begin
            ch = CHAR_A + {2'b00, group};
        end
        else
        begin
            ch = CHAR_2 + {2'b00, group - LETTER_COUNT};
        end
        return ch;
    endfunction

endpackage

@@ design/base32_stream_encoder_unit.sv @@
// Top level of the streaming base32 (RFC 4648, unpadded) encoder.
`timescale 1ns / 1ps

// Byte stream in, base32 ASCII characters out, no padding. Each input
// transaction carries one message byte on s_axis_tdata, with s_axis_tlast set
// on the final byte of a message. Each output transaction carries one
// character (A-Z, 2-7); m_axis_tuser marks the last character caused by a
// given byte and m_axis_tlast marks the last character of the message, which
// includes the zero-filled flush character when the final byte leaves bits
// over. A byte gives one or two characters, a final byte up to three.
// Throughput is set by the character side: one character per cycle while
// m_axis_tready is high; a long message gives 1.6 characters per byte on
// average. The input side takes a byte every cycle as long as the
// QUEUE_DEPTH-entry queue between the byte front end and the character
// back end has room, so short bursts are absorbed without stalling. An
// accepted byte passes the queue slot, the current-entry register and the
// output register. No configuration; reset clears the residue and the queue.
module base32_stream_encoder_unit
#(
    parameter int QUEUE_DEPTH = b32se_pkg::B32SE_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // final_byte

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic       m_axis_tuser,   // [0] run_end
    output logic       m_axis_tlast    // message_end
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    b32se_pkg::b32se_entry_t      push_entry;
    b32se_pkg::b32se_entry_t      head;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_not_empty;
    logic                         q_full;
    logic [LVL_W-1:0]             q_level;
    logic [b32se_pkg::SYM_W-1:0]  symbol;

    // front end: residue tracking and splitting into 5-bit groups
    b32se_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .q_full     (q_full),
        .push       (q_push),
        .entry      (push_entry)
    );

    // decouples byte intake from character output
    b32se_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .not_empty  (q_not_empty),
        .full       (q_full),
        .level      (q_level)
    );

    // back end: one character per cycle into the output register unless the output stalls
    b32se_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_not_empty (q_not_empty),
        .pop         (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .symbol      (symbol),
        .run_end     (m_axis_tuser),
        .message_end (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, symbol};

    // ---- assertions ----

    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_level != LVL_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_level != '0))
        else $error("queue popped while empty");

    // end of message is always also end of the byte's run
    a_msg_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("message end without run end");

    // only alphabet characters leave the block
    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((symbol >= b32se_pkg::CHAR_A) && (symbol <= b32se_pkg::CHAR_Z)) ||
            ((symbol >= b32se_pkg::CHAR_2) && (symbol <= b32se_pkg::CHAR_7)))
        else $error("character outside base32 alphabet");

endmodule

@@ design/b32se_front.sv @@
// Front end: accepts bytes, joins them with the residue and splits them into base32 groups.
`timescale 1ns / 1ps

module b32se_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              data_byte,
    input  logic                    final_byte,
    input  logic                    q_full,
    output logic                    push,
    output b32se_pkg::b32se_entry_t entry
);

    logic [3:0]  res_bits_reg,  res_bits_next;
    logic [2:0]  res_count_reg, res_count_next;

    logic [3:0]  cnt;        // valid bits in buf, 8..12
    logic [11:0] buf_bits;
    logic [3:0]  shift;
    logic [14:0] aligned;    // buf left-aligned, zero-filled on the right
    logic        two_full;
    logic [3:0]  left;
    logic [3:0]  left_mask;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cnt       = {1'b0, res_count_reg} + 4'd8;
        buf_bits  = {res_bits_reg, data_byte};
        shift     = 4'd15 - cnt;
        aligned   = {3'b000, buf_bits} << shift;
        two_full  = (cnt >= 4'd10);
        left      = two_full ? (cnt - 4'd10) : (cnt - 4'd5);
        left_mask = 4'hF >> (4'd4 - left);

        entry.groups[0] = aligned[14:10];
        entry.groups[1] = aligned[9:5];
        entry.groups[2] = aligned[4:0];
        entry.n_chars   = (two_full ? 2'd2 : 2'd1)
                        + {1'b0, (final_byte && (left != 4'd0))};
        entry.last      = final_byte;

        res_bits_next  = res_bits_reg;
        res_count_next = res_count_reg;
        if (push)
        begin
            if (final_byte)
            begin
                res_bits_next  = 4'd0;
                res_count_next = 3'd0;
            end
            else
            begin
                res_bits_next  = buf_bits[3:0] & left_mask;
                res_count_next = left[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bits_reg  <= 4'd0;
            res_count_reg <= 3'd0;
        end
        else
        begin
            res_bits_reg  <= res_bits_next;
            res_count_reg <= res_count_next;
        end
    end

endmodule

@@ design/b32se_queue.sv @@
// Small register queue of classified bytes between front end and back end.
`timescale 1ns / 1ps

module b32se_queue
#(
    parameter int DEPTH = b32se_pkg::B32SE_QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  b32se_pkg::b32se_entry_t      push_entry,
    input  logic                         pop,
    output b32se_pkg::b32se_entry_t      head,
    output logic                         not_empty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

    b32se_pkg::b32se_entry_t slots_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg,  level_next;

    assign head      = slots_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign full      = (level_reg == LVL_FULL);
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/b32se_back.sv @@
// Back end: walks one queued entry a character per cycle, unless the output stalls, into the output register.
`timescale 1ns / 1ps

module b32se_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  b32se_pkg::b32se_entry_t           head,
    input  logic                              q_not_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [b32se_pkg::SYM_W-1:0]       symbol,
    output logic                              run_end,
    output logic                              message_end
);

    b32se_pkg::b32se_entry_t cur_reg, cur_next;
    logic                    cur_valid_reg, cur_valid_next;
    logic [1:0]              idx_reg, idx_next;

    logic                              out_valid_reg, out_valid_next;
    logic [b32se_pkg::SYM_W-1:0]       symbol_reg, symbol_next;
    logic                              run_end_reg, run_end_next;
    logic                              message_end_reg, message_end_next;

    logic                                load;
    logic                                last_char;
    logic                                cur_done;
    logic [b32se_pkg::GROUP_W-1:0]       group;

    always_comb
    begin
        case (idx_reg)
            2'd0:    group = cur_reg.groups[0];
            2'd1:    group = cur_reg.groups[1];
            2'd2:    group = cur_reg.groups[2];
            default: group = cur_reg.groups[0];
        endcase

        load      = cur_valid_reg && (!out_valid_reg || out_ready);
        last_char = (idx_reg == (cur_reg.n_chars - 2'd1));
        cur_done  = load && last_char;
        pop       = q_not_empty && (!cur_valid_reg || cur_done);

        cur_next       = pop ? head : cur_reg;
        cur_valid_next = pop ? 1'b1 : (cur_done ? 1'b0 : cur_valid_reg);
        idx_next       = pop ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);

        out_valid_next   = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        symbol_next      = load ? b32se_pkg::b32_char(group) : symbol_reg;
        run_end_next     = load ? last_char : run_end_reg;
        message_end_next = load ? (last_char && cur_reg.last) : message_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        symbol_reg      <= symbol_next;
        run_end_reg     <= run_end_next;
        message_end_reg <= message_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = symbol_reg;
    assign run_end     = run_end_reg;
    assign message_end = message_end_reg;

endmodule

@@ tb/sv/base32_stream_encoder_unit_test.sv @@
// Self-checking testbench for the streaming base32 encoder top level.
`timescale 1ns / 1ps

// Bytes go in as messages of random length; each accepted byte is run through
// a local base32 model that queues the characters it must cause, and every
// character transaction on the output is checked against the oldest queued one.
module base32_stream_encoder_unit_test;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_BYTES  = 300;
    localparam int MAX_MSG_LEN   = 12;
    localparam int LONG_MSG_LEN  = 40;
    localparam int PHASE_LEN     = 100;   // accepted bytes per idle phase
    localparam int HOLD_OFFSET   = 230;   // bytes into the run before the long stall
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    localparam int SEND_IDLE_LIGHT = 7;
    localparam int SEND_IDLE_HEAVY = 78;
    localparam int RECV_IDLE_LIGHT = 7;
    localparam int RECV_IDLE_HEAVY = 78;

    localparam int          LETTERS  = 26;
    localparam logic [6:0]  ASCII_A  = 7'h41;
    localparam logic [6:0]  ASCII_2  = 7'h32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
        logic       hold_before;   // wait for the output to drain first
    } byte_item_t;

    typedef struct packed {
        logic [6:0] symbol;
        logic       run_end;
        logic       message_end;
    } b32_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // final_byte

    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] symbol, [7] zero
    logic       m_axis_tuser;           // [0] run_end
    logic       m_axis_tlast;           // message_end

    byte_item_t pending_bytes[$];
    b32_char_t  expected_chars[$];

    // encoder model state
    logic [3:0] residue_bits = 4'h0;
    int         residue_count = 0;

    int bytes_accepted;
    int messages_accepted;
    int chars_predicted;
    int chars_checked;
    int error_count = 0;
    int directed_count = 0;
    int hold_left;
    logic hold_armed;
    int cycle_count = 0;

    base32_stream_encoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // A-Z for groups 0..25, then 2-7
    function automatic logic [6:0] base32_symbol(input logic [4:0] grp);
        if (grp < LETTERS)
        begin
            return ASCII_A + 7'(grp);
        end
        return ASCII_2 + 7'(grp - LETTERS);
    endfunction

    // Appends one byte to the residue, queues the characters it causes and
    // returns how many there were.
    function automatic int encode_byte(input logic [7:0] data, input logic fin);
        logic [11:0] acc;
        logic [4:0]  grp;
        int          cnt;
        int          n;
        b32_char_t   ch;
        acc = {residue_bits, data};
        cnt = residue_count + 8;
        n = 0;
        while (cnt >= 5)
        begin
            cnt -= 5;
            grp = 5'(acc >> cnt);
            ch = '{symbol: base32_symbol(grp), run_end: 1'b0, message_end: 1'b0};
            expected_chars.push_back(ch);
            n++;
        end
        // flush: leftover bits zero-filled on the right
        if (fin && cnt > 0)
        begin
            grp = 5'(acc << (5 - cnt));
            ch = '{symbol: base32_symbol(grp), run_end: 1'b0, message_end: 1'b0};
            expected_chars.push_back(ch);
            n++;
        end
        ch = expected_chars.pop_back();
        ch.run_end = 1'b1;
        ch.message_end = fin;
        expected_chars.push_back(ch);
        if (fin)
        begin
            residue_bits = 4'h0;
            residue_count = 0;
        end
        else
        begin
            residue_bits = 4'(acc & ((12'd1 << cnt) - 12'd1));
            residue_count = cnt;
        end
        return n;
    endfunction

    // Idle rates by phase: sender light / receiver heavy, then swapped, then none.
    function automatic int send_idle_pct();
        if (bytes_accepted < directed_count + PHASE_LEN)
        begin
            return SEND_IDLE_LIGHT;
        end
        if (bytes_accepted < directed_count + 2 * PHASE_LEN)
        begin
            return SEND_IDLE_HEAVY;
        end
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (bytes_accepted < directed_count + PHASE_LEN)
        begin
            return RECV_IDLE_HEAVY;
        end
        if (bytes_accepted < directed_count + 2 * PHASE_LEN)
        begin
            return RECV_IDLE_LIGHT;
        end
        return 0;
    endfunction

    function automatic void add_message(input logic [7:0] msg[$], input logic hold);
        byte_item_t item;
        foreach (msg[i])
        begin
            item.data_byte = msg[i];
            item.final_byte = (i == msg.size() - 1);
            item.hold_before = hold && (i == 0);
            pending_bytes.push_back(item);
        end
    endfunction

    // Sender: offers the next queued byte unless idling or holding for a drain.
    always @(posedge clk or negedge rst_n)
    begin
        byte_item_t item;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct() &&
                (!pending_bytes[0].hold_before ||
                 (!s_axis_tvalid && chars_predicted == chars_checked)))
            begin
                item = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.data_byte;
                s_axis_tlast  <= item.final_byte;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long output stall while the sender keeps pushing, to fill the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && bytes_accepted >= directed_count + HOLD_OFFSET)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // Monitor: predicts on each input transaction, checks each output transaction.
    always @(posedge clk or negedge rst_n)
    begin
        int        n;
        b32_char_t want;
        if (!rst_n)
        begin
            bytes_accepted    <= 0;
            messages_accepted <= 0;
            chars_predicted   <= 0;
            chars_checked     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                n = encode_byte(s_axis_tdata, s_axis_tlast);
                bytes_accepted  <= bytes_accepted + 1;
                chars_predicted <= chars_predicted + n;
                if (s_axis_tlast)
                begin
                    messages_accepted <= messages_accepted + 1;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                chars_checked <= chars_checked + 1;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character 0x%02h, nothing pending", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== {1'b0, want.symbol})
                    begin
                        $error("symbol: expected 0x%02h, got 0x%02h",
                               {1'b0, want.symbol}, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.run_end)
                    begin
                        $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.message_end)
                    begin
                        $error("message_end: expected %0b, got %0b",
                               want.message_end, m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] msg[$];
        int         total;
        int         len;
        logic       hold;
        logic       hold_placed;

        // Directed: lengths 1..5 end on every residue count 3,1,4,2,0, so the
        // final byte gives two, three, two, three and two characters, and the
        // five-byte message flushes with no leftover bits.
        msg = '{8'h00};                             add_message(msg, 1'b1);
        msg = '{8'hFF};                             add_message(msg, 1'b0);
        msg = '{8'hFF, 8'h00};                      add_message(msg, 1'b0);
        msg = '{8'h80, 8'h01, 8'hFF};               add_message(msg, 1'b0);
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};        add_message(msg, 1'b1);
        msg = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80}; add_message(msg, 1'b0);
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; add_message(msg, 1'b0);
        directed_count = pending_bytes.size();

        // Random messages; one drain pause lands mid-run in the second phase.
        total = 0;
        hold_placed = 1'b0;
        while (total < RANDOM_BYTES)
        begin
            len = ($urandom_range(0, 19) == 0) ? LONG_MSG_LEN : $urandom_range(1, MAX_MSG_LEN);
            msg.delete();
            repeat (len)
            begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
            hold = !hold_placed && (total >= PHASE_LEN + PHASE_LEN / 2);
            hold_placed |= hold;
            add_message(msg, hold);
            total += len;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || s_axis_tvalid || chars_checked != chars_predicted)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_chars.size());
        end
        $display("run covered %0d bytes in %0d messages, %0d characters checked,",
                 bytes_accepted, messages_accepted, chars_checked);
        $display("with three idle mixes, a drain pause and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (error_count == 0 && expected_chars.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/b32se_pkg.sv
design/b32se_front.sv
design/b32se_queue.sv
design/b32se_back.sv
design/base32_stream_encoder_unit.sv
tb/sv/base32_stream_encoder_unit_test.sv
